// File: rtl/core/chs_pkg.sv
// ----------------------------------------------------------------------------
// Chained hash set package
// Shared operation and status codes, and the queue entry type.
// ----------------------------------------------------------------------------
package chs_pkg;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    localparam int KEY_W = 31;

    // One classified request passed from the front end to the back end.
    typedef struct packed {
        logic [1:0]       op;
        logic [KEY_W-1:0] key;
    } t_req;

endpackage

// File: rtl/core/chs_front.sv
// ----------------------------------------------------------------------------
// Chained hash set front end
// Accepts requests, computes the bucket by serial restoring modulo and
// pushes the classified request with its bucket into a two-entry queue.
// ----------------------------------------------------------------------------
module chs_front #(
    parameter int BKT_W = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [6:0]        i_count,
    input  logic              i_valid,
    output logic              o_ready,
    input  chs_pkg::t_req     i_req,
    output logic              o_valid,
    input  logic              i_ready,
    output chs_pkg::t_req     o_req,
    output logic [BKT_W-1:0]  o_bkt
);
    import chs_pkg::*;

    localparam int BUCKETS = 1 << BKT_W;

    logic          r_busy, n_busy;
    logic [4:0]    r_bit, n_bit;
    logic [7:0]    r_rem, n_rem;
    logic [6:0]    r_div, n_div;
    t_req          r_req, n_req;
    logic [7:0]    w_sh;
    logic [6:0]    w_cnt;

    // Queue of two entries.
    t_req             r_q_req [2];
    logic [BKT_W-1:0] r_q_bkt [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_fill;
    logic             w_push, w_pop;

    // Effective bucket count, clamped to 1..BUCKETS.
    always_comb begin
        w_cnt = i_count;
        if (i_count == 7'd0) w_cnt = 7'd1;
        else if (BUCKETS < 128 && {25'd0, i_count} > BUCKETS) w_cnt = 7'(BUCKETS);
    end

    assign o_ready = !r_busy && (r_fill != 2'd2);
    assign w_sh    = {r_rem[6:0], r_req.key[r_bit]};
    assign w_push  = r_busy && (r_bit == 5'd0);
    assign w_pop   = (r_fill != 2'd0) && i_ready;

    // Modulo: one key bit per cycle, most significant first.
    always_comb begin
        n_busy = r_busy;
        n_bit  = r_bit;
        n_rem  = r_rem;
        n_div  = r_div;
        n_req  = r_req;
        if (i_valid && o_ready) begin
            n_busy = 1'b1;
            n_bit  = 5'(KEY_W - 1);
            n_rem  = 8'd0;
            n_div  = w_cnt;
            n_req  = i_req;
        end else if (r_busy) begin
            n_rem = (w_sh >= {1'b0, r_div}) ? w_sh - {1'b0, r_div} : w_sh;
            n_bit = r_bit - 5'd1;
            if (r_bit == 5'd0) n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            r_busy <= n_busy;
            if (w_push) r_wp <= !r_wp;
            if (w_pop) r_rp <= !r_rp;
            r_fill <= r_fill + {1'b0, w_push} - {1'b0, w_pop};
        end
        r_bit <= n_bit;
        r_rem <= n_rem;
        r_div <= n_div;
        r_req <= n_req;
        if (w_push) begin
            r_q_req[r_wp] <= r_req;
            r_q_bkt[r_wp] <= BKT_W'(n_rem);
        end
    end

    assign o_valid = (r_fill != 2'd0);
    assign o_req   = r_q_req[r_rp];
    assign o_bkt   = r_q_bkt[r_rp];
endmodule

// File: rtl/core/chs_back.sv
// ----------------------------------------------------------------------------
// Chained hash set back end
// Executes insert, search and remove on the node pool, walking chains node by
// node, and holds the result in an output register.
// ----------------------------------------------------------------------------
module chs_back #(
    parameter int BKT_W  = 6,
    parameter int NODE_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  chs_pkg::t_req     i_req,
    input  logic [BKT_W-1:0]  i_bkt,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [2:0]        o_res
);
    import chs_pkg::*;

    localparam int BUCKETS = 1 << BKT_W;
    localparam int NODES   = 1 << NODE_W;
    localparam logic [NODE_W:0] NIL = (NODE_W+1)'(NODES);

    localparam logic [3:0] S_IDLE = 4'd0, S_HEAD = 4'd1, S_HEADW = 4'd2,
                           S_RD = 4'd3, S_CMP = 4'd4, S_INS = 4'd5,
                           S_POP = 4'd6, S_OUT = 4'd7, S_FILL = 4'd8;

    logic [BUCKETS-1:0]   r_bv;
    logic [NODE_W:0]      m_head [BUCKETS];
    logic [KEY_W-1:0]     m_key  [NODES];
    logic [NODE_W:0]      m_link [NODES];
    logic [NODE_W-1:0]    m_free [NODES];

    logic [3:0]           r_st;
    t_req                 r_req;
    logic [BKT_W-1:0]     r_bkt;
    logic [NODE_W:0]      r_cur, r_prev, r_fcnt;
    logic [NODE_W:0]      r_head_q, r_link_q;
    logic [KEY_W-1:0]     r_key_q;
    logic [NODE_W-1:0]    r_free_q;
    logic [NODE_W:0]      r_steps;
    logic [NODE_W:0]      r_fillp;
    logic                 r_ov;
    logic [2:0]           r_res;
    logic [NODE_W:0]      w_head;

    assign o_ready = (r_st == S_IDLE) && !r_ov;
    assign o_valid = r_ov;
    assign o_res   = r_res;
    assign w_head  = r_bv[r_bkt] ? r_head_q : NIL;

    // Sequencer: a chain walk reads a node, then compares and follows.
    always_ff @(posedge i_clk) begin
        r_head_q <= m_head[r_bkt];
        r_key_q  <= m_key[r_cur[NODE_W-1:0]];
        r_link_q <= m_link[r_cur[NODE_W-1:0]];
        r_free_q <= m_free[NODE_W'(r_fcnt - 1'b1)];
        if (!i_rst_n) begin
            r_st    <= S_FILL;
            r_fillp <= '0;
            r_bv    <= '0;
            r_fcnt  <= (NODE_W+1)'(NODES);
            r_ov    <= 1'b0;
        end else begin
            if (r_ov && i_ready) r_ov <= 1'b0;
            case (r_st)
                S_FILL: begin
                    m_free[r_fillp[NODE_W-1:0]] <= r_fillp[NODE_W-1:0];
                    r_fillp <= r_fillp + 1'b1;
                    if (r_fillp == NIL - 1'b1) r_st <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_valid && !r_ov) begin
                        r_req   <= i_req;
                        r_bkt   <= i_bkt;
                        r_prev  <= NIL;
                        r_steps <= '0;
                        r_st    <= S_HEAD;
                    end
                end
                S_HEAD: r_st <= S_HEADW;
                S_HEADW: begin
                    r_cur <= w_head;
                    case (r_req.op)
                        OP_INSERT: begin
                            if (r_fcnt == '0) begin
                                r_res <= {ST_FULL, 1'b0};
                                r_st  <= S_OUT;
                            end else begin
                                r_st <= S_POP;
                            end
                        end
                        OP_SEARCH, OP_REMOVE: r_st <= S_RD;
                        default: begin
                            r_res <= {ST_DONE, 1'b0};
                            r_st  <= S_OUT;
                        end
                    endcase
                end
                S_POP: r_st <= S_INS;
                S_INS: begin
                    m_key[r_free_q]  <= r_req.key;
                    m_link[r_free_q] <= w_head;
                    m_head[r_bkt]    <= {1'b0, r_free_q};
                    r_bv[r_bkt]      <= 1'b1;
                    r_fcnt           <= r_fcnt - 1'b1;
                    r_res            <= {ST_DONE, 1'b0};
                    r_st             <= S_OUT;
                end
                S_RD: begin
                    if (r_cur[NODE_W] || r_steps == NIL) begin
                        r_res <= {ST_NOTFOUND, 1'b0};
                        r_st  <= S_OUT;
                    end else begin
                        r_st <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (r_key_q == r_req.key) begin
                        r_res <= {ST_DONE, 1'b1};
                        if (r_req.op == OP_REMOVE) begin
                            if (!r_prev[NODE_W]) begin
                                m_link[r_prev[NODE_W-1:0]] <= r_link_q;
                            end else begin
                                m_head[r_bkt] <= r_link_q;
                                r_bv[r_bkt]   <= 1'b1;
                            end
                            m_free[r_fcnt[NODE_W-1:0]] <= r_cur[NODE_W-1:0];
                            r_fcnt <= r_fcnt + 1'b1;
                        end
                        r_st <= S_OUT;
                    end else begin
                        r_prev  <= r_cur;
                        r_cur   <= r_link_q;
                        r_steps <= r_steps + 1'b1;
                        r_st    <= S_RD;
                    end
                end
                S_OUT: begin
                    if (!r_ov) begin
                        r_ov <= 1'b1;
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

// File: rtl/core/chained_hash_set.sv
// ----------------------------------------------------------------------------
// Chained hash set
// Hash set of 31-bit keys with separate chaining over a fixed node pool.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload
// s_axis    in         tdata[1:0] op, tdata[32:2] key
// m_axis    out        tdata[0] hit, tdata[2:1] status
// cfg       in         bucket count, 7 bits
//
// The front end computes the bucket modulo, one key bit a cycle.
// The back end reads the bucket head, then links in a free node or walks the
// chain node by node. After reset it fills the free stack and
// takes nothing meanwhile, while the front end may take up to two transfers.
// A two-entry queue lets the front run ahead of the back.
module chained_hash_set #(
    parameter int BKT_W  = 6,
    parameter int NODE_W = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // op[1:0], key[32:2]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // hit[0], status[2:1]
);
    import chs_pkg::*;

    logic [6:0]       r_count;
    t_req             w_req, q_req;
    logic             q_valid, q_ready;
    logic [BKT_W-1:0] q_bkt;
    logic [2:0]       w_res;

    // Bucket count register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_count <= 7'd7;
        else if (i_cfg_we) r_count <= i_cfg_wdata;
    end

    assign w_req.op  = s_axis_tdata[1:0];
    assign w_req.key = s_axis_tdata[32:2];

    chs_front #(.BKT_W(BKT_W)) u_front (
        .i_clk, .i_rst_n, .i_count(r_count),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_req(w_req),
        .o_valid(q_valid), .i_ready(q_ready), .o_req(q_req), .o_bkt(q_bkt)
    );

    chs_back #(.BKT_W(BKT_W), .NODE_W(NODE_W)) u_back (
        .i_clk, .i_rst_n,
        .i_valid(q_valid), .o_ready(q_ready), .i_req(q_req), .i_bkt(q_bkt),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(w_res)
    );

    assign m_axis_tdata = {5'd0, w_res};

    // A refused insert never reports a hit.
    a_full_nohit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[2:1] == ST_FULL |-> !m_axis_tdata[0])
        else $error("full status with hit");
    // A hit always carries the done status.
    a_hit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[2:1] == ST_DONE)
        else $error("hit without done status");
    // A stalled result is held.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");
endmodule

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// Chained hash set testbench
// Drives insert, search, remove and unused-op transfers, mostly with random
// idling on both streams, predicts each result from a local copy of chains
// and free stack, and checks the result stream in order. The bucket count is
// changed between phases while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
    import chs_pkg::*;

    localparam int NBKT       = 64;
    localparam int NNODE      = 256;
    localparam int NIL        = NNODE;
    localparam int CYCLE_CAP  = 5000000;
    localparam int HOLD_LEN   = 400;

    typedef struct packed {
        logic       hit;
        logic [1:0] status;
    } t_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [6:0]  i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;    // op[1:0], key[32:2], zeros above
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;    // hit[0], status[2:1], zeros above

    chained_hash_set dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Local copy of the set.
    int unsigned bkt_cnt;
    int unsigned heads [NBKT];
    logic [30:0] keys  [NNODE];
    int unsigned links [NNODE];
    int unsigned free_stk [NNODE];
    int unsigned free_num;

    t_req  pending_reqs [$];
    t_res  expected_res [$];
    bit    failed = 1'b0;
    bit    idle_on;
    bit    src_pause;
    bit    hold_go;
    int    hold_left = 0;
    int    src_gap = 0;
    int    snk_gap = 0;
    int    cycles = 0;
    int    n_acc = 0;
    int    n_seen = 0;

    // Clock.
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic void reset_set();
        bkt_cnt = 7;
        for (int i = 0; i < NBKT; i++) heads[i] = NIL;
        for (int i = 0; i < NNODE; i++) begin
            free_stk[i] = i;
            links[i]    = NIL;
            keys[i]     = '0;
        end
        free_num = NNODE;
    endfunction

    // Works out the result of one request and updates the local set.
    function automatic t_res apply_request(t_req r);
        t_res        res;
        int unsigned n, b, cur, prev, node;
        res = '0;
        n = (bkt_cnt == 0) ? 1 : ((bkt_cnt > NBKT) ? NBKT : bkt_cnt);
        b = r.key % n;
        if (r.op == OP_INSERT) begin
            if (free_num == 0) begin
                res.status = ST_FULL;
            end else begin
                free_num--;
                node        = free_stk[free_num];
                keys[node]  = r.key;
                links[node] = heads[b];
                heads[b]    = node;
                res.status  = ST_DONE;
            end
        end else if (r.op == OP_SEARCH || r.op == OP_REMOVE) begin
            res.status = ST_NOTFOUND;
            prev = NIL;
            cur  = heads[b];
            while (cur != NIL) begin
                if (keys[cur] == r.key) begin
                    res.hit    = 1'b1;
                    res.status = ST_DONE;
                    if (r.op == OP_REMOVE) begin
                        if (prev != NIL) links[prev] = links[cur];
                        else heads[b] = links[cur];
                        free_stk[free_num] = cur;
                        free_num++;
                    end
                    break;
                end
                prev = cur;
                cur  = links[cur];
            end
        end
        return res;
    endfunction

    // Driver: offers the oldest pending request, with bursts of idling.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end else if (s_axis_tvalid && n_acc == n_seen) begin
            // hold the offered transfer
        end else begin
            n_seen = n_acc;
            if (src_gap > 0) begin
                src_gap       <= src_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0 && !src_pause) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {7'd0, pending_reqs[0].key, pending_reqs[0].op};
                if (idle_on && $urandom_range(0, 5) == 0) src_gap <= $urandom_range(1, 17);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Predict on each accepted request and retire it from the pending queue.
    always @(posedge i_clk) begin
        t_req acc;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            acc.op  = s_axis_tdata[1:0];
            acc.key = s_axis_tdata[32:2];
            expected_res.push_back(apply_request(acc));
            void'(pending_reqs.pop_front());
            n_acc++;
        end
    end

    // Receiver side: random stalls and one long hold-off when requested.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_go && hold_left < HOLD_LEN) begin
            hold_left     <= hold_left + 1;
            m_axis_tready <= 1'b0;
        end else if (snk_gap > 0) begin
            snk_gap       <= snk_gap - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (idle_on && $urandom_range(0, 5) == 0) snk_gap <= $urandom_range(1, 17);
        end
    end

    // Monitor: compares each result transfer with the oldest expectation.
    always @(posedge i_clk) begin
        t_res got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.hit    = m_axis_tdata[0];
            got.status = m_axis_tdata[2:1];
            if (expected_res.size() == 0) begin
                $display("%0t: unexpected result hit=%0d status=%0d", $time, got.hit,
                    got.status);
                failed = 1'b1;
            end else begin
                want = expected_res.pop_front();
                if (got.hit !== want.hit) begin
                    $display("%0t: hit expected %0d actual %0d", $time, want.hit, got.hit);
                    failed = 1'b1;
                end
                if (got.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status,
                        got.status);
                    failed = 1'b1;
                end
            end
        end
    end

    // Cycle limit.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_CAP) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic [30:0] rand_key(int unsigned span);
        if (span == 0) return 31'($urandom);
        return 31'($urandom_range(0, span - 1));
    endfunction

    task automatic push_req(logic [1:0] op, logic [30:0] key);
        t_req r;
        r.op  = op;
        r.key = key;
        pending_reqs.push_back(r);
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || s_axis_tvalid || expected_res.size() != 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_count(logic [6:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        bkt_cnt = value;
    endtask

    // Random phase: mostly operations on a small key space so that
    // searches and removes find stored keys.
    task automatic random_phase(int count, int unsigned span);
        int unsigned sel;
        logic [1:0]  op;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(0, 99);
            op  = (sel < 40) ? OP_INSERT : (sel < 70) ? OP_SEARCH :
                  (sel < 97) ? OP_REMOVE : OP_UNUSED;
            push_req(op, ($urandom_range(0, 9) == 0) ? rand_key(0) : rand_key(span));
        end
    endtask

    initial begin
        logic [6:0] counts [6];
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        idle_on   = 1'b1;
        src_pause = 1'b0;
        hold_go   = 1'b0;
        reset_set();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: extremes of keys, every operation, empty chain, op 3.
        push_req(OP_SEARCH, 31'd5);
        push_req(OP_REMOVE, 31'd5);
        push_req(OP_INSERT, 31'h7fffffff);
        push_req(OP_INSERT, 31'd0);
        push_req(OP_INSERT, 31'd7);
        push_req(OP_INSERT, 31'd7);
        push_req(OP_SEARCH, 31'h7fffffff);
        push_req(OP_SEARCH, 31'd14);
        push_req(OP_REMOVE, 31'd0);
        push_req(OP_REMOVE, 31'd7);
        push_req(OP_SEARCH, 31'd7);
        push_req(OP_REMOVE, 31'd7);
        push_req(OP_REMOVE, 31'd7);
        push_req(OP_UNUSED, 31'h2aaaaaaa);
        push_req(OP_UNUSED, 31'h55555555);
        wait_drained();

        // Zero count (treated as one), then saturation above the bucket count.
        write_count(7'd0);
        push_req(OP_INSERT, 31'd3);
        push_req(OP_SEARCH, 31'd3);
        push_req(OP_SEARCH, 31'h7fffffff);
        wait_drained();
        write_count(7'd127);
        push_req(OP_SEARCH, 31'd3);
        push_req(OP_INSERT, 31'd200);
        push_req(OP_SEARCH, 31'd200);
        wait_drained();

        // Fill the pool past full, with one long receiver hold-off at the start.
        write_count(7'd64);
        hold_go = 1'b1;
        for (int i = 0; i < 262; i++) push_req(OP_INSERT, rand_key(0));
        wait_drained();
        src_pause = 1'b1;
        random_phase(40, 40);
        repeat (30) @(posedge i_clk);
        src_pause = 1'b0;
        wait_drained();
        for (int i = 0; i < 200; i++) push_req(OP_REMOVE, rand_key(0));
        wait_drained();

        // Random phases under several bucket counts.
        counts = '{7'd1, 7'd64, 7'd13, 7'd2, 7'd100, 7'd7};
        foreach (counts[k]) begin
            write_count(counts[k]);
            random_phase(90, (k % 2) ? 300 : 40);
            wait_drained();
        end

        // Last part without idling.
        idle_on = 1'b0;
        write_count(7'd5);
        random_phase(100, 60);
        wait_drained();

        if (!failed) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/chs_pkg.sv
rtl/core/chs_front.sv
rtl/core/chs_back.sv
rtl/core/chained_hash_set.sv
dv/testbench.sv
